@@ rtl/assert_macros.svh @@
// assertion helpers, empty when synthesised
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LRF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lrf assertion failed");
`define LRF_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("lrf assertion failed");
`define LRF_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("lrf assertion failed");
`else
`define LRF_ASSERT(lbl, clk, rst_n, prop)
`define LRF_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define LRF_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

@@ rtl/lrf_pkg.sv @@
`timescale 1ns / 1ps
package lrf_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int RADIUS_W = 15;
	localparam int ENERGY_W = 16;
	localparam int CLASS_W = 8;
	localparam int CIDX_W = 3;
	localparam int NUM_CLS = 4;
	localparam int NUM_CNT = 2 * NUM_CLS;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd1600;

	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	localparam logic [CLASS_W-1:0] FLAG_TRUE_A = 8'd0;
	localparam logic [CLASS_W-1:0] FLAG_TRUE_B = 8'd10;
	localparam logic [CLASS_W-1:0] FLAG_RANDOM = 8'd1;
	localparam logic [CLASS_W-1:0] FLAG_SCATTER = 8'd2;

	localparam logic [1:0] CLS_TRUE = 2'd0;
	localparam logic [1:0] CLS_RANDOM = 2'd1;
	localparam logic [1:0] CLS_SCATTER = 2'd2;
	localparam logic [1:0] CLS_OTHER = 2'd3;

	typedef struct packed {
		logic       upd;
		logic       rej;
		logic [1:0] cls;
	} cnt_ctl_t;

	function automatic logic [1:0] class_of(input logic [CLASS_W-1:0] flag);
		logic [1:0] c;
		case (flag) inside
			FLAG_TRUE_A, FLAG_TRUE_B: c = CLS_TRUE;
			FLAG_RANDOM: c = CLS_RANDOM;
			FLAG_SCATTER: c = CLS_SCATTER;
			default: c = CLS_OTHER;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/lrf_counters.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lrf_counters #(
	parameter int COUNT_WIDTH = lrf_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lrf_pkg::cnt_ctl_t           ctl,
	input  logic [lrf_pkg::CIDX_W-1:0]  rd_index,
	output logic [COUNT_WIDTH-1:0]      rd_data
);
	import lrf_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] cnt_q [NUM_CNT];
	logic [NUM_CNT-1:0] inc;

	always_comb begin
		for (int i = 0; i < NUM_CLS; i++) begin
			inc[i] = ctl.upd && (ctl.cls == 2'(i));
			inc[i + NUM_CLS] = ctl.upd && ctl.rej && (ctl.cls == 2'(i));
		end
	end

	for (genvar g = 0; g < NUM_CNT; g++) begin : g_cnt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[g] <= '0;
			end else if (inc[g] && cnt_q[g] != CNT_MAX) begin
				cnt_q[g] <= cnt_q[g] + 1'b1;
			end
		end

		`LRF_ASSERT(a_mono, clk, arst_n, cnt_q[g] >= $past(cnt_q[g]))
		`LRF_ASSERT_NEXT(a_step, clk, arst_n, inc[g] && cnt_q[g] != CNT_MAX, cnt_q[g] == COUNT_WIDTH'($past(cnt_q[g]) + 1'b1))
	end

	assign rd_data = cnt_q[rd_index];

	`LRF_ASSERT_IMP(a_rej_upd, clk, arst_n, ctl.rej, ctl.upd)

endmodule

@@ rtl/lor_radial_fov_filter_top.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Radial field-of-view filter for coincidence events.
// s_axis carries one request per item: tuser 0 is an event (two hits and a
// class flag), tuser 1 asks for one of eight statistics counters.
// An event whose line of response passes farther than fov_radius from the
// origin in the XY plane is dropped; any other event comes out on m_axis
// unchanged with tuser 0. A counter request comes out with tuser 1.
// cfg_valid writes fov_radius (always ready); write only while idle.
// Throughput is one item per cycle while m_axis does not stall. An accepted
// item passes an input product stage, a square stage, a partial product
// stage, two adder stages and the output register on its way to m_axis. The
// 66-bit exact compare is split over these multiplier and adder stages.
// Each stage holds its item while the one after it is full, so a stall on
// m_axis_tready fills the bubbles first and then holds s_axis_tready low;
// nothing is lost or repeated.
// Reset empties the pipeline, clears all counters and sets fov_radius to
// 1600. Counters update as an event leaves the last stage, so a counter
// read sees every event accepted before it.
module lor_radial_fov_filter_top #(
	parameter int COORD_WIDTH = lrf_pkg::COORD_WIDTH_DEF,
	parameter int COUNT_WIDTH = lrf_pkg::COUNT_WIDTH_DEF,
	localparam int IN_DW = ((6 * COORD_WIDTH + 2 * lrf_pkg::ENERGY_W + lrf_pkg::CLASS_W
		+ lrf_pkg::CIDX_W + 7) / 8) * 8,
	localparam int OUT_DW = ((6 * COORD_WIDTH + 2 * lrf_pkg::ENERGY_W + lrf_pkg::CLASS_W
		+ COUNT_WIDTH + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// hit1_z, hit1_y, hit1_x, hit1_energy, hit2_z, hit2_y, hit2_x, hit2_energy,
	// event_class, counter_index
	input  logic [IN_DW-1:0]              s_axis_tdata,
	// req_type
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_z1, out_y1, out_x1, out_e1, out_z2, out_y2, out_x2, out_e2,
	// out_class, count_value
	output logic [OUT_DW-1:0]             m_axis_tdata,
	// result_kind
	output logic                          m_axis_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lrf_pkg::RADIUS_W-1:0]  cfg_data
);
	import lrf_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int NW = COUNT_WIDTH;
	localparam int Z1_LO = 0;
	localparam int Y1_LO = CW;
	localparam int X1_LO = 2 * CW;
	localparam int Y2_LO = 4 * CW + ENERGY_W;
	localparam int X2_LO = 5 * CW + ENERGY_W;
	localparam int CLS_LO = 6 * CW + 2 * ENERGY_W;
	localparam int IDX_LO = CLS_LO + CLASS_W;
	localparam int CNT_LO = CLS_LO + CLASS_W;
	localparam int R2W = 2 * RADIUS_W;
	localparam int AW = 2 * CW + 1;
	localparam int LW = CW + 1;
	localparam int HW = AW - LW;
	localparam int ACW = 2 * AW;
	localparam int SW = 2 * CW + 2;
	localparam int SLW = CW + 1;
	localparam int SHW = SW - SLW;
	localparam int RW = R2W + SW;
	localparam int CMPW = (ACW > RW) ? ACW : RW;

	logic [RADIUS_W-1:0] fov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fov_q <= RADIUS_RESET;
		end else if (cfg_valid) begin
			fov_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// stage valids and the ready chain
	logic v1, v2, v3, v4, v5, m_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, out_rdy;

	assign out_rdy = !m_valid_q || m_axis_tready;
	assign rdy5 = !v5 || out_rdy;
	assign rdy4 = !v4 || rdy5;
	assign rdy3 = !v3 || rdy4;
	assign rdy2 = !v2 || rdy3;
	assign rdy1 = !v1 || rdy2;
	assign s_axis_tready = rdy1;

	logic [IN_DW-1:0] data_s1, data_s2, data_s3, data_s4, data_s5;
	logic user_s1, user_s2, user_s3, user_s4, user_s5;

	// stage 1: cross products and differences
	logic signed [CW-1:0] x1, y1, x2, y2;
	logic signed [2*CW-1:0] p1_s1, p2_s1;
	logic signed [CW:0] dx_s1, dy_s1;
	logic [R2W-1:0] r2_s1;

	assign x1 = $signed(s_axis_tdata[X1_LO +: CW]);
	assign y1 = $signed(s_axis_tdata[Y1_LO +: CW]);
	assign x2 = $signed(s_axis_tdata[X2_LO +: CW]);
	assign y2 = $signed(s_axis_tdata[Y2_LO +: CW]);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			data_s1 <= s_axis_tdata;
			user_s1 <= s_axis_tuser;
			p1_s1 <= x1 * y2;
			p2_s1 <= x2 * y1;
			dx_s1 <= x1 - x2;
			dy_s1 <= y1 - y2;
			r2_s1 <= fov_q * fov_q;
		end
	end

	// stage 2: magnitude of cross, squared differences
	logic signed [2*CW:0] xprod;
	logic signed [2*CW+1:0] dxsq, dysq;
	logic [AW-1:0] ac_s2;
	logic [SW-1:0] dx2_s2, dy2_s2;
	logic [R2W-1:0] r2_s2;

	assign xprod = p1_s1 - p2_s1;
	assign dxsq = dx_s1 * dx_s1;
	assign dysq = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			data_s2 <= data_s1;
			user_s2 <= user_s1;
			ac_s2 <= xprod[2*CW] ? $unsigned(-xprod) : $unsigned(xprod);
			dx2_s2 <= $unsigned(dxsq);
			dy2_s2 <= $unsigned(dysq);
			r2_s2 <= r2_s1;
		end
	end

	// stage 3: partial products of cross squared, sum of squares
	logic [HW-1:0] ah;
	logic [LW-1:0] al;
	logic [2*HW-1:0] pp_hh_s3;
	logic [HW+LW-1:0] pp_hl_s3;
	logic [2*LW-1:0] pp_ll_s3;
	logic [SW-1:0] s_s3;
	logic [R2W-1:0] r2_s3;

	assign ah = ac_s2[AW-1:LW];
	assign al = ac_s2[LW-1:0];

	always_ff @(posedge clk) begin
		if (rdy3) begin
			data_s3 <= data_s2;
			user_s3 <= user_s2;
			pp_hh_s3 <= ah * ah;
			pp_hl_s3 <= ah * al;
			pp_ll_s3 <= al * al;
			s_s3 <= dx2_s2 + dy2_s2;
			r2_s3 <= r2_s2;
		end
	end

	// stage 4: cross squared, partial products of the radius side
	logic [ACW-1:0] ac2_s4;
	logic [R2W+SLW-1:0] rl_s4;
	logic [R2W+SHW-1:0] rh_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			data_s4 <= data_s3;
			user_s4 <= user_s3;
			ac2_s4 <= (ACW'(pp_hh_s3) << (2 * LW)) + (ACW'(pp_hl_s3) << (LW + 1))
				+ ACW'(pp_ll_s3);
			rl_s4 <= r2_s3 * s_s3[SLW-1:0];
			rh_s4 <= r2_s3 * s_s3[SW-1:SLW];
		end
	end

	// stage 5: radius side sum
	logic [ACW-1:0] ac2_s5;
	logic [RW-1:0] rhs_s5;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			data_s5 <= data_s4;
			user_s5 <= user_s4;
			ac2_s5 <= ac2_s4;
			rhs_s5 <= (RW'(rh_s4) << SLW) + RW'(rl_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
		end else begin
			if (rdy1) v1 <= s_axis_tvalid;
			if (rdy2) v2 <= v1;
			if (rdy3) v3 <= v2;
			if (rdy4) v4 <= v3;
			if (rdy5) v5 <= v4;
		end
	end

	// output stage: compare, counters, result register
	logic reject;
	logic leave;
	cnt_ctl_t cnt_ctl;
	logic [NW-1:0] cnt_rd;
	logic [OUT_DW-1:0] out_next;
	logic [OUT_DW-1:0] m_data_q;
	logic m_user_q;

	assign reject = CMPW'(ac2_s5) > CMPW'(rhs_s5);
	assign leave = v5 && out_rdy;

	assign cnt_ctl.upd = leave && (user_s5 == KIND_EVENT);
	assign cnt_ctl.rej = leave && (user_s5 == KIND_EVENT) && reject;
	assign cnt_ctl.cls = class_of(data_s5[CLS_LO +: CLASS_W]);

	lrf_counters #(
		.COUNT_WIDTH(NW)
	) u_counters (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cnt_ctl),
		.rd_index(data_s5[IDX_LO +: CIDX_W]),
		.rd_data (cnt_rd)
	);

	always_comb begin
		out_next = '0;
		if (user_s5 == KIND_COUNT) begin
			out_next[CNT_LO +: NW] = cnt_rd;
		end else begin
			out_next[Z1_LO +: CNT_LO] = data_s5[Z1_LO +: CNT_LO];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_rdy) begin
			m_valid_q <= v5 && ((user_s5 == KIND_COUNT) || !reject);
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			m_data_q <= out_next;
			m_user_q <= user_s5;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_user_q;

	`LRF_ASSERT_IMP(a_cnt_clean, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_COUNT, m_axis_tdata[CNT_LO-1:0] == '0)
	`LRF_ASSERT_IMP(a_evt_clean, clk, arst_n, m_axis_tvalid && m_axis_tuser == KIND_EVENT, m_axis_tdata[CNT_LO +: NW] == '0)
	`LRF_ASSERT_NEXT(a_s5_hold, clk, arst_n, v5 && !out_rdy, v5)

endmodule

@@ dv/fov_filter_checker.sv @@
`timescale 1ns / 1ps
module fov_filter_checker #(
	parameter int IN_DW = 144,
	parameter int OUT_DW = 168
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	// hit1_z, hit1_y, hit1_x, hit1_energy, hit2_z, hit2_y, hit2_x, hit2_energy,
	// event_class, counter_index
	input  logic [IN_DW-1:0]  s_axis_tdata,
	// req_type
	input  logic              s_axis_tuser,
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// out_z1, out_y1, out_x1, out_e1, out_z2, out_y2, out_x2, out_e2,
	// out_class, count_value
	input  logic [OUT_DW-1:0] m_axis_tdata,
	// result_kind
	input  logic              m_axis_tuser,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [lrf_pkg::RADIUS_W-1:0] cfg_data,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic              kind;
		logic [OUT_DW-1:0] data;
	} fov_output_t;

	logic [lrf_pkg::RADIUS_W-1:0] radius;
	logic [31:0] class_tally [lrf_pkg::NUM_CNT];
	fov_output_t due_outputs [$];
	int errs = 0;

	assign fail_count = errs;

	function automatic logic [1:0] class_slot(input logic [7:0] flag);
		case (flag)
			lrf_pkg::FLAG_TRUE_A, lrf_pkg::FLAG_TRUE_B: return lrf_pkg::CLS_TRUE;
			lrf_pkg::FLAG_RANDOM: return lrf_pkg::CLS_RANDOM;
			lrf_pkg::FLAG_SCATTER: return lrf_pkg::CLS_SCATTER;
			default: return lrf_pkg::CLS_OTHER;
		endcase
	endfunction

	// exact form of: distance from origin to the line through both hits > r
	function automatic logic outside_fov(input logic signed [15:0] x1, y1, x2, y2,
			input logic [lrf_pkg::RADIUS_W-1:0] r);
		longint xprod, dx, dy;
		logic [63:0] ac, dsq, r2;
		logic [127:0] lhs, rhs;
		xprod = longint'(x1) * longint'(y2) - longint'(x2) * longint'(y1);
		dx = longint'(x1) - longint'(x2);
		dy = longint'(y1) - longint'(y2);
		ac = (xprod < 0) ? -xprod : xprod;
		dsq = dx * dx + dy * dy;
		r2 = 64'(r) * 64'(r);
		lhs = 128'(ac) * 128'(ac);
		rhs = 128'(r2) * 128'(dsq);
		return lhs > rhs;
	endfunction

	task automatic bump(input int idx);
		if (class_tally[idx] != '1)
			class_tally[idx] = class_tally[idx] + 32'd1;
	endtask

	task automatic check_field(input string fname, input logic [31:0] want, got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		fov_output_t got, want;
		logic [1:0] slot;
		logic [7:0] flag;
		if (!arst_n) begin
			due_outputs.delete();
			radius = lrf_pkg::RADIUS_RESET;
			for (int i = 0; i < lrf_pkg::NUM_CNT; i++)
				class_tally[i] = '0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tuser, m_axis_tdata};
				if (due_outputs.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d data %h",
						$time, got.kind, got.data);
					errs++;
				end else begin
					want = due_outputs.pop_front();
					check_field("result_kind", 32'(want.kind), 32'(got.kind));
					for (int i = 0; i < 8; i++)
						check_field($sformatf("%s%0d",
							(i % 4 == 0) ? "out_z" : (i % 4 == 1) ? "out_y" :
							(i % 4 == 2) ? "out_x" : "out_e", i / 4 + 1),
							32'(want.data[i*16 +: 16]), 32'(got.data[i*16 +: 16]));
					check_field("out_class", 32'(want.data[135:128]), 32'(got.data[135:128]));
					check_field("count_value", want.data[167:136], got.data[167:136]);
				end
			end
			if (cfg_valid && cfg_ready)
				radius = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				flag = s_axis_tdata[135:128];
				if (s_axis_tuser == lrf_pkg::KIND_COUNT) begin
					due_outputs.push_back('{lrf_pkg::KIND_COUNT,
						{class_tally[s_axis_tdata[138:136]], 136'b0}});
				end else begin
					slot = class_slot(flag);
					bump(int'(slot));
					if (outside_fov(s_axis_tdata[47:32], s_axis_tdata[31:16],
							s_axis_tdata[111:96], s_axis_tdata[95:80], radius))
						bump(lrf_pkg::NUM_CLS + int'(slot));
					else
						due_outputs.push_back('{lrf_pkg::KIND_EVENT, {32'b0, flag,
							s_axis_tdata[127:112], s_axis_tdata[111:96],
							s_axis_tdata[95:80], s_axis_tdata[79:64],
							s_axis_tdata[63:48], s_axis_tdata[47:32],
							s_axis_tdata[31:16], s_axis_tdata[15:0]}});
				end
			end
			pending <= due_outputs.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

	localparam int IN_DW = ((6 * 16 + 2 * lrf_pkg::ENERGY_W + lrf_pkg::CLASS_W
		+ lrf_pkg::CIDX_W + 7) / 8) * 8;
	localparam int OUT_DW = ((6 * 16 + 2 * lrf_pkg::ENERGY_W + lrf_pkg::CLASS_W
		+ 32 + 7) / 8) * 8;
	localparam int ITEMS_PER_PHASE = 322;
	localparam int QUIET_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DW-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DW-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [lrf_pkg::RADIUS_W-1:0] cfg_data;
	int fail_count;
	int pending;

	int src_max_gap = 0;
	int sink_max_gap = 0;
	int sink_hold = 0;
	int quiet_cycles = 0;

	lor_radial_fov_filter_top dut (.*);

	fov_filter_checker #(.IN_DW(IN_DW), .OUT_DW(OUT_DW)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [IN_DW-1:0] pack_request(input logic [15:0] z1, y1, x1, e1,
			z2, y2, x2, e2, input logic [7:0] flag, input logic [2:0] cidx);
		return IN_DW'({cidx, flag, e2, x2, y2, z2, e1, x1, y1, z1});
	endfunction

	task automatic offer(input logic req, input logic [IN_DW-1:0] word);
		int gap;
		gap = $urandom_range(src_max_gap, 0);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= word;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// wait until every result is out and rejected events have drained
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_request(input logic [lrf_pkg::RADIUS_W-1:0] r, output logic req,
			output logic [IN_DW-1:0] word);
		int pick, bound, d, a, b;
		logic [15:0] x1, y1, x2, y2;
		logic [7:0] flag;
		pick = $urandom_range(99, 0);
		bound = int'(r) * 3;
		if (bound < 16) bound = 16;
		if (bound > 32767) bound = 32767;
		x1 = 16'($urandom);
		y1 = 16'($urandom);
		x2 = 16'($urandom);
		y2 = 16'($urandom);
		req = lrf_pkg::KIND_EVENT;
		if (pick < 10) begin
			req = lrf_pkg::KIND_COUNT;
		end else if (pick < 16) begin
			x2 = x1;
			y2 = y1;
		end else if (pick < 26) begin
			x2 = -x1;
			y2 = -y1;
		end else if (pick < 38) begin
			// line parallel to an axis, just inside, on or just outside the radius
			d = int'(r) + int'($urandom_range(2, 0)) - 1;
			if (d < 0) d = 0;
			if (d > 32767) d = 32767;
			if ($urandom_range(1, 0) == 1) d = -d;
			a = $urandom_range(1000, 1);
			b = $urandom_range(1000, 1);
			if ($urandom_range(1, 0) == 1) begin
				x1 = 16'(d);
				x2 = 16'(d);
				y1 = 16'(-a);
				y2 = 16'(b);
			end else begin
				y1 = 16'(d);
				y2 = 16'(d);
				x1 = 16'(-a);
				x2 = 16'(b);
			end
		end else if (pick >= 58) begin
			x1 = 16'(int'($urandom_range(2 * bound, 0)) - bound);
			y1 = 16'(int'($urandom_range(2 * bound, 0)) - bound);
			x2 = 16'(int'($urandom_range(2 * bound, 0)) - bound);
			y2 = 16'(int'($urandom_range(2 * bound, 0)) - bound);
		end
		case ($urandom_range(5, 0))
			0: flag = lrf_pkg::FLAG_TRUE_A;
			1: flag = lrf_pkg::FLAG_TRUE_B;
			2: flag = lrf_pkg::FLAG_RANDOM;
			3: flag = lrf_pkg::FLAG_SCATTER;
			default: flag = 8'($urandom);
		endcase
		word = pack_request(16'($urandom), y1, x1, 16'($urandom), 16'($urandom), y2, x2,
			16'($urandom), flag, 3'($urandom));
	endtask

	initial begin : sink
		int gap;
		m_axis_tready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (sink_hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end
			gap = $urandom_range(sink_max_gap, 0);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic req;
		logic [IN_DW-1:0] word;
		logic [lrf_pkg::RADIUS_W-1:0] r;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items at the reset radius
		src_max_gap = 2;
		sink_max_gap = 2;
		offer(lrf_pkg::KIND_COUNT, pack_request(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h0, 16'h0, 8'd0, 3'd0));
		// both hits on one xy point
		offer(lrf_pkg::KIND_EVENT, pack_request(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			16'h0, 16'h0, lrf_pkg::FLAG_TRUE_A, 3'd0));
		offer(lrf_pkg::KIND_EVENT, pack_request(16'h8000, 16'h7fff, 16'h8000, 16'hffff,
			16'h7fff, 16'h7fff, 16'h8000, 16'h0, lrf_pkg::FLAG_TRUE_B, 3'd7));
		// line through the origin
		offer(lrf_pkg::KIND_EVENT, pack_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h0,
			16'h8000, 16'h8000, 16'h8000, 16'hffff, lrf_pkg::FLAG_RANDOM, 3'd0));
		// far lines at the coordinate extremes
		offer(lrf_pkg::KIND_EVENT, pack_request(16'h1234, 16'h8000, 16'h7fff, 16'h5a5a,
			16'hedcb, 16'h7fff, 16'h7fff, 16'ha5a5, lrf_pkg::FLAG_SCATTER, 3'd0));
		offer(lrf_pkg::KIND_EVENT, pack_request(16'h0, 16'h8000, 16'h8000, 16'h1,
			16'h0, 16'h8000, 16'h7fff, 16'h2, 8'hff, 3'd0));
		// lines exactly on the radius and one unit beyond
		offer(lrf_pkg::KIND_EVENT, pack_request(16'h0, -16'sd100, 16'd1600, 16'd500,
			16'h0, 16'd100, 16'd1600, 16'd600, 8'd3, 3'd0));
		offer(lrf_pkg::KIND_EVENT, pack_request(16'h0, -16'sd100, 16'd1601, 16'd500,
			16'h0, 16'd100, 16'd1601, 16'd600, 8'd11, 3'd0));
		offer(lrf_pkg::KIND_EVENT, pack_request(16'h7, -16'sd1600, -16'sd50, 16'd9,
			16'h8, -16'sd1600, 16'd70, 16'd10, 8'd9, 3'd0));
		offer(lrf_pkg::KIND_EVENT, pack_request(16'h7, -16'sd1601, -16'sd50, 16'd9,
			16'h8, -16'sd1601, 16'd70, 16'd10, lrf_pkg::FLAG_RANDOM, 3'd0));
		for (int i = 0; i < lrf_pkg::NUM_CNT; i++)
			offer(lrf_pkg::KIND_COUNT, pack_request(16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 8'($urandom), 3'(i)));

		for (int p = 0; p < 6; p++) begin
			settle();
			case (p)
				0: r = '0;
				1: r = '1;
				3: r = 15'd1;
				4: r = lrf_pkg::RADIUS_RESET;
				default: r = 15'($urandom_range(4000, 2));
			endcase
			cfg_valid <= 1'b1;
			cfg_data <= r;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			cfg_valid <= 1'b0;
			src_max_gap = (p % 3 == 1) ? 0 : 5;
			sink_max_gap = (p % 3 == 2) ? 0 : 5;
			if (p == 3) begin
				src_max_gap = 0;
				sink_hold = 80;
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				random_request(r, req, word);
				offer(req, word);
			end
		end

		settle();
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
